@@ rtl/btl_pkg.sv @@
`default_nettype none
package btl_pkg;

    // One source byte, or the end marker.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } btl_in_t;

    // One token.
    typedef struct packed {
        logic [6:0]  token_kind;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last;
    } btl_out_t;

    // The tokens that one source byte closes, first token in item[0].
    typedef struct packed {
        btl_out_t [2:0] item;
        logic [1:0]     count;
    } btl_res_t;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_NUM, M_DOT, M_FRAC, M_STR,
        M_LT, M_GT, M_DOLLAR, M_DPRE
    } lex_mode_t;

    localparam logic [6:0] K_LTGT   = 7'd4;
    localparam logic [6:0] K_GE     = 7'd5;
    localparam logic [6:0] K_LE     = 7'd6;
    localparam logic [6:0] K_GT     = 7'd7;
    localparam logic [6:0] K_LT     = 7'd8;
    localparam logic [6:0] K_SYM0   = 7'd9;
    localparam logic [6:0] K_DOLLAR = 7'd21;
    localparam logic [6:0] K_WORD0  = 7'd22;
    localparam logic [6:0] K_IDENT  = 7'd64;
    localparam logic [6:0] K_INT    = 7'd65;
    localparam logic [6:0] K_FLOAT  = 7'd66;
    localparam logic [6:0] K_STRING = 7'd67;
    localparam logic [6:0] K_EOL    = 7'd68;
    localparam logic [6:0] K_EOF    = 7'd69;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DECIMAL = 2'd1;
    localparam logic [1:0] ERR_STRING  = 2'd2;
    localparam logic [1:0] ERR_CHAR    = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    localparam int NUM_WORDS = 42;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hexletter(input logic [7:0] c);
        return ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [7:0] lower_ch(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    // Kind of a one-character symbol; zero when the byte is none of them.
    function automatic logic [6:0] single_sym(input logic [7:0] c);
        logic [6:0] k;
        k = '0;
        case (c)
            "+": k = K_SYM0;
            "-": k = K_SYM0 + 7'd1;
            "*": k = K_SYM0 + 7'd2;
            "/": k = K_SYM0 + 7'd3;
            "=": k = K_SYM0 + 7'd4;
            ",": k = K_SYM0 + 7'd5;
            ":": k = K_SYM0 + 7'd6;
            ".": k = K_SYM0 + 7'd7;
            "(": k = K_SYM0 + 7'd8;
            ")": k = K_SYM0 + 7'd9;
            "%": k = K_SYM0 + 7'd10;
            "#": k = K_SYM0 + 7'd11;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Moves the text so that its first character sits in the top byte.
    function automatic logic [95:0] left_align(input logic [95:0] s);
        logic [95:0] t;
        t = s;
        for (int k = 0; k < 12; k++) begin
            if (t[95:88] == 8'd0) begin
                t = t << 8;
            end
        end
        return t;
    endfunction

    function automatic logic [95:0] word_text(input int unsigned i);
        logic [95:0] s;
        case (i)
            0:  s = "not";
            1:  s = "and";
            2:  s = "or";
            3:  s = "mod";
            4:  s = "program";
            5:  s = "endprogram";
            6:  s = "if";
            7:  s = "else";
            8:  s = "elseif";
            9:  s = "endif";
            10: s = "select";
            11: s = "case";
            12: s = "default";
            13: s = "endselect";
            14: s = "for";
            15: s = "to";
            16: s = "step";
            17: s = "next";
            18: s = "repeat";
            19: s = "until";
            20: s = "while";
            21: s = "endwhile";
            22: s = "exit";
            23: s = "dim";
            24: s = "as";
            25: s = "int";
            26: s = "float";
            27: s = "string";
            28: s = "pchar";
            29: s = "function";
            30: s = "endfunction";
            31: s = "return";
            32: s = "const";
            33: s = "struct";
            34: s = "endstruct";
            35: s = "extern";
            36: s = "endextern";
            37: s = "new";
            38: s = "delete";
            39: s = "true";
            40: s = "false";
            41: s = "null";
            default: s = '0;
        endcase
        return left_align(s);
    endfunction

    // Directive names without the dollar, first character in the top byte.
    function automatic logic [63:0] dir_text(input int unsigned i);
        logic [95:0] s;
        case (i)
            0: s = "include";
            1: s = "use";
            2: s = "link";
            3: s = "option";
            default: s = '0;
        endcase
        s = left_align(s);
        return s[95:32];
    endfunction

    function automatic logic [2:0] dir_len(input int unsigned i);
        logic [2:0] n;
        case (i)
            0: n = 3'd7;
            1: n = 3'd3;
            2: n = 3'd4;
            3: n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

@@ rtl/basic_token_lexer.sv @@
`default_nettype none
// Streaming BASIC lexer. One source byte (or the end marker) is taken per
// request on the s_ channel and every token it closes comes out on the m_
// channel, one token per request, in source order, with its kind, length,
// line number and error code; the last token caused by a byte carries last.
// A byte is lexed combinationally: the lexer state registers and a small
// combinational step feed a four-entry result queue, and the first token of
// a byte is offered on the m_ channel from the queue head once the tokens
// ahead of it have gone. The input is ready whenever the queue holds at most
// one token, so with a ready consumer one byte is taken every cycle while
// each byte closes at most one token; a byte that closes more stalls the
// input while its tokens drain, since the queue sends one token a cycle.
// After an error or the end marker the lexer swallows every byte without
// output until reset. MAX_WORD bounds the keyword buffer, LINE_BITS and
// LENGTH_BITS set where the line and length counters saturate.
module basic_token_lexer #(
    parameter int MAX_WORD    = 11,
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  btl_pkg::btl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output btl_pkg::btl_out_t m_data
);
    import btl_pkg::*;

    btl_res_t res;
    logic     take;

    // A request is taken when the queue has room for all it may produce.
    assign take = s_valid && s_ready;

    btl_core #(
        .MAX_WORD    (MAX_WORD),
        .LINE_BITS   (LINE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_data (s_data),
        .res     (res)
    );

    btl_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (take),
        .res     (res),
        .space   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

@@ rtl/btl_core.sv @@
`default_nettype none
module btl_core #(
    parameter int MAX_WORD    = 11,
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  btl_pkg::btl_in_t  in_data,
    output btl_pkg::btl_res_t res
);
    import btl_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_CAP  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_CAP = {LINE_BITS{1'b1}};
    localparam int CMP_BYTES = (MAX_WORD < 12) ? MAX_WORD : 12;

    lex_mode_t                     mode_reg, mode_next;
    logic [MAX_WORD-1:0][7:0]      wb_reg, wb_next;
    logic [LENGTH_BITS-1:0]        cnt_reg, cnt_next;
    logic [LINE_BITS-1:0]          line_reg, line_next;
    logic                          hex_reg, hex_next;
    logic                          acr_reg, acr_next;
    logic                          halt_reg, halt_next;

    function automatic logic [15:0] sat16(input logic [32:0] x);
        return (x > 33'd65535) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic btl_res_t push_res(input btl_res_t r, input logic [6:0] k,
                                          input logic [15:0] len, input logic [15:0] ln,
                                          input logic [1:0] e);
        btl_res_t t;
        t = r;
        if (t.count < 2'd3) begin
            t.item[t.count] = '{token_kind: k, token_length: len, line_number: ln,
                                error_code: e, last: 1'b0};
            t.count = t.count + 2'd1;
        end
        return t;
    endfunction

    function automatic logic [MAX_WORD-1:0][7:0] set_letter(
        input logic [MAX_WORD-1:0][7:0] w, input logic [LENGTH_BITS-1:0] n,
        input logic [7:0] c);
        logic [MAX_WORD-1:0][7:0] t;
        t = w;
        for (int j = 0; j < MAX_WORD; j++) begin
            if (n == LENGTH_BITS'(j)) begin
                t[j] = lower_ch(c);
            end
        end
        return t;
    endfunction

    function automatic logic [6:0] word_kind(input logic [MAX_WORD-1:0][7:0] w,
                                             input logic [LENGTH_BITS-1:0] n);
        logic [95:0] v;
        logic [6:0]  k;
        v = '0;
        k = K_IDENT;
        for (int j = 0; j < CMP_BYTES; j++) begin
            v[95-8*j -: 8] = w[j];
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (v == word_text(i)) begin
                k = K_WORD0 + 7'(i);
            end
        end
        if (n > LENGTH_BITS'(MAX_WORD)) begin
            k = K_IDENT;
        end
        return k;
    endfunction

    always_comb begin
        btl_res_t    r;
        logic [7:0]  c;
        logic [7:0]  lc;
        logic        run;
        logic        do_ident;
        logic        do_idle;
        logic        hit;
        logic        ok;
        logic [1:0]  hit_idx;
        logic [63:0] d;
        logic [6:0]  sk;

        mode_next = mode_reg;
        wb_next   = wb_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        hex_next  = hex_reg;
        acr_next  = acr_reg;
        halt_next = halt_reg;
        r         = '0;
        c         = in_data.ch;
        run       = 1'b0;
        do_ident  = 1'b0;
        do_idle   = 1'b0;
        hit       = 1'b0;
        ok        = 1'b0;
        hit_idx   = '0;
        d         = '0;
        sk        = '0;

        if (!halt_reg) begin
            if (in_data.end_of_input) begin
                acr_next = 1'b0;
                if (mode_reg == M_DPRE) begin
                    // Directive prefix cut short: dollar, the word, end of file.
                    r = push_res(r, K_DOLLAR, 16'd1, sat16(33'(line_reg)), ERR_NONE);
                    r = push_res(r, word_kind(wb_reg, cnt_reg), sat16(33'(cnt_reg)),
                                 sat16(33'(line_reg)), ERR_NONE);
                    r = push_res(r, K_EOF, 16'd0, sat16(33'(line_reg)), ERR_NONE);
                    halt_next = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    c   = CH_LF;
                    run = 1'b1;
                end
            end else if (acr_reg && (c == CH_LF)) begin
                acr_next = 1'b0;
            end else begin
                acr_next = (c == CH_CR);
                if (c == CH_CR) begin
                    c = CH_LF;
                end
                run = 1'b1;
            end
        end
        lc = lower_ch(c);

        if (run) begin
            case (mode_next)
                M_COMMENT: begin
                    if (c == CH_LF) begin
                        do_idle = 1'b1;
                    end
                end
                M_IDENT: do_ident = 1'b1;
                M_NUM: begin
                    if (is_digit(c) || (hex_next && is_hexletter(c))) begin
                        if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                    end else if (c == ".") begin
                        if (hex_next) begin
                            r = push_res(r, K_EOF, 16'd0, sat16(33'(line_next)), ERR_DECIMAL);
                            halt_next = 1'b1;
                            mode_next = M_IDLE;
                        end else begin
                            if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                            mode_next = M_DOT;
                        end
                    end else begin
                        r = push_res(r, K_INT, sat16(33'(cnt_next)), sat16(33'(line_next)),
                                     ERR_NONE);
                        do_idle = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                        mode_next = M_FRAC;
                    end else begin
                        r = push_res(r, K_EOF, 16'd0, sat16(33'(line_next)), ERR_DECIMAL);
                        halt_next = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                    end else begin
                        r = push_res(r, K_FLOAT, sat16(33'(cnt_next)), sat16(33'(line_next)),
                                     ERR_NONE);
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        r = push_res(r, K_STRING, sat16(33'(cnt_next)), sat16(33'(line_next)),
                                     ERR_NONE);
                        mode_next = M_IDLE;
                    end else if (c == CH_LF) begin
                        r = push_res(r, K_EOF, 16'd0, sat16(33'(line_next)), ERR_STRING);
                        halt_next = 1'b1;
                        mode_next = M_IDLE;
                    end else begin
                        if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                    end
                end
                M_LT: begin
                    if (c == ">") begin
                        r = push_res(r, K_LTGT, 16'd2, sat16(33'(line_next)), ERR_NONE);
                        mode_next = M_IDLE;
                    end else if (c == "=") begin
                        r = push_res(r, K_LE, 16'd2, sat16(33'(line_next)), ERR_NONE);
                        mode_next = M_IDLE;
                    end else begin
                        r = push_res(r, K_LT, 16'd1, sat16(33'(line_next)), ERR_NONE);
                        do_idle = 1'b1;
                    end
                end
                M_GT: begin
                    if (c == "=") begin
                        r = push_res(r, K_GE, 16'd2, sat16(33'(line_next)), ERR_NONE);
                        mode_next = M_IDLE;
                    end else begin
                        r = push_res(r, K_GT, 16'd1, sat16(33'(line_next)), ERR_NONE);
                        do_idle = 1'b1;
                    end
                end
                M_DOLLAR: begin
                    if (is_digit(c)) begin
                        mode_next = M_NUM;
                        hex_next  = 1'b1;
                        cnt_next  = LENGTH_BITS'(2);
                    end else if ((lc == "i") || (lc == "u") || (lc == "l") || (lc == "o")) begin
                        mode_next = M_DPRE;
                        wb_next   = set_letter('0, '0, c);
                        cnt_next  = LENGTH_BITS'(1);
                    end else begin
                        r = push_res(r, K_DOLLAR, 16'd1, sat16(33'(line_next)), ERR_NONE);
                        do_idle = 1'b1;
                    end
                end
                M_DPRE: begin
                    // Does the byte extend one of the directive names?
                    for (int i = 0; i < 4; i++) begin
                        d  = dir_text(i);
                        ok = (LENGTH_BITS'(dir_len(i)) > cnt_next);
                        for (int j = 0; j < 8; j++) begin
                            if ((LENGTH_BITS'(j) < cnt_next) && (wb_next[j] != d[63-8*j -: 8]))
                            begin
                                ok = 1'b0;
                            end
                            if ((LENGTH_BITS'(j) == cnt_next) && (d[63-8*j -: 8] != lc)) begin
                                ok = 1'b0;
                            end
                        end
                        if (ok && !hit) begin
                            hit     = 1'b1;
                            hit_idx = 2'(i);
                        end
                    end
                    if (hit) begin
                        wb_next = set_letter(wb_next, cnt_next, c);
                        if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                        if (cnt_next == LENGTH_BITS'(dir_len(32'(hit_idx)))) begin
                            r = push_res(r, 7'(hit_idx), sat16(33'(cnt_next) + 33'd1),
                                         sat16(33'(line_next)), ERR_NONE);
                            mode_next = M_IDLE;
                        end
                    end else begin
                        r = push_res(r, K_DOLLAR, 16'd1, sat16(33'(line_next)), ERR_NONE);
                        mode_next = M_IDENT;
                        do_ident  = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            if (do_ident) begin
                if (is_alpha(c) || is_digit(c)) begin
                    wb_next = set_letter(wb_next, cnt_next, c);
                    if (cnt_next != LEN_CAP) cnt_next = cnt_next + LENGTH_BITS'(1);
                end else begin
                    r = push_res(r, word_kind(wb_next, cnt_next), sat16(33'(cnt_next)),
                                 sat16(33'(line_next)), ERR_NONE);
                    do_idle = 1'b1;
                end
            end

            if (do_idle) begin
                mode_next = M_IDLE;
                sk        = single_sym(c);
                if ((c == " ") || (c == CH_TAB)) begin
                    mode_next = M_IDLE;
                end else if (c == CH_APOS) begin
                    mode_next = M_COMMENT;
                end else if (c == CH_LF) begin
                    r = push_res(r, K_EOL, 16'd1, sat16(33'(line_next)), ERR_NONE);
                    if (line_next != LINE_CAP) line_next = line_next + LINE_BITS'(1);
                end else if (c == "$") begin
                    mode_next = M_DOLLAR;
                end else if (is_digit(c)) begin
                    mode_next = M_NUM;
                    hex_next  = 1'b0;
                    cnt_next  = LENGTH_BITS'(1);
                end else if (c == "<") begin
                    mode_next = M_LT;
                end else if (c == ">") begin
                    mode_next = M_GT;
                end else if (sk != 7'd0) begin
                    r = push_res(r, sk, 16'd1, sat16(33'(line_next)), ERR_NONE);
                end else if (c == CH_QUOTE) begin
                    mode_next = M_STR;
                    cnt_next  = '0;
                end else if (is_alpha(c)) begin
                    mode_next = M_IDENT;
                    wb_next   = set_letter('0, '0, c);
                    cnt_next  = LENGTH_BITS'(1);
                end else begin
                    r = push_res(r, K_EOF, 16'd1, sat16(33'(line_next)), ERR_CHAR);
                    halt_next = 1'b1;
                    mode_next = M_IDLE;
                end
            end

            // The end marker closes the file unless an error already did.
            if (in_data.end_of_input && !halt_next) begin
                r = push_res(r, K_EOF, 16'd0, sat16(33'(line_next)), ERR_NONE);
                halt_next = 1'b1;
            end
        end

        if (r.count != 2'd0) begin
            r.item[r.count - 2'd1].last = 1'b1;
        end
        res = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            wb_reg   <= '0;
            cnt_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            hex_reg  <= 1'b0;
            acr_reg  <= 1'b0;
            halt_reg <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            wb_reg   <= wb_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            hex_reg  <= hex_next;
            acr_reg  <= acr_next;
            halt_reg <= halt_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/btl_fifo.sv @@
`default_nettype none
module btl_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  btl_pkg::btl_res_t res,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output btl_pkg::btl_out_t m_data
);
    import btl_pkg::*;

    btl_out_t [3:0] q_reg, q_next;
    logic [2:0]     count_reg, count_next;

    logic       pop;
    logic [2:0] base;
    logic [2:0] npush;

    assign pop     = (count_reg != 3'd0) && m_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = q_reg[0];
    // Room for the three tokens one byte can close.
    assign space   = (count_reg <= 3'd1);

    always_comb begin
        logic [2:0] off;
        off        = '0;
        base       = count_reg - {2'b00, pop};
        npush      = push ? {1'b0, res.count} : 3'd0;
        q_next     = q_reg;
        for (int k = 0; k < 4; k++) begin
            off = 3'(k) - base;
            if (3'(k) < base) begin
                if (pop && (k < 3)) begin
                    q_next[k] = q_reg[(k < 3) ? k + 1 : k];
                end
            end else if (off < npush) begin
                q_next[k] = res.item[off[1:0]];
            end
        end
        count_next = base + npush;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule
`default_nettype wire
